>>> hdl/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while in reset
`define BGMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, skipped while in reset
`define BGMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/bgmc_pkg.sv
// Package: types, codes and helpers of the button gesture mode controller
package bgmc_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned DEB_W      = 10;
  localparam int unsigned GAP_W      = 12;
  localparam int unsigned LONG_W     = 16;
  localparam int unsigned CMP_W      = (TIMER_BITS > LONG_W) ? TIMER_BITS : LONG_W;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_DOUBLE_GAP = 2'd1,
    REG_LONG_PRESS = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_LONG   = 2'd2,
    GEST_DOUBLE = 2'd3
  } gesture_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_PAUSE    = 3'd1,
    CMD_RESUME   = 3'd2,
    CMD_PREVIOUS = 3'd3,
    CMD_NEXT     = 3'd4,
    CMD_VOL_DOWN = 3'd5,
    CMD_VOL_UP   = 3'd6
  } command_e;

  typedef enum logic [2:0] {
    MODE_PLAY  = 3'b001,
    MODE_TRACK = 3'b010,
    MODE_VOL   = 3'b100
  } mode_e;

  localparam logic [1:0] MODE_CODE_PLAY  = 2'd0;
  localparam logic [1:0] MODE_CODE_TRACK = 2'd1;
  localparam logic [1:0] MODE_CODE_VOL   = 2'd2;

  localparam logic [1:0] PLAY_STATE_PLAYING = 2'd1;
  localparam logic [1:0] PLAY_STATE_WAITING = 2'd2;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ms;
    logic [GAP_W-1:0]  double_gap_ms;
    logic [LONG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       raw_level;
    logic [1:0] play_state;
  } word_t;

  function automatic timer_t sat_inc(input timer_t v);
    sat_inc = (v == '1) ? v : v + timer_t'(1);
  endfunction

endpackage

>>> hdl/bgmc_regs.sv
// Configuration register file behind the APB-style port
module bgmc_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bgmc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bgmc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bgmc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output bgmc_pkg::cfg_t                       cfg_o
);

  bgmc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        bgmc_pkg::REG_DEBOUNCE:   cfg_d.debounce_ms   = pwdata[bgmc_pkg::DEB_W-1:0];
        bgmc_pkg::REG_DOUBLE_GAP: cfg_d.double_gap_ms = pwdata[bgmc_pkg::GAP_W-1:0];
        bgmc_pkg::REG_LONG_PRESS: cfg_d.long_press_ms = pwdata[bgmc_pkg::LONG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bgmc_pkg::REG_DEBOUNCE:
        prdata = bgmc_pkg::APB_DATA_W'(cfg_q.debounce_ms);
      bgmc_pkg::REG_DOUBLE_GAP:
        prdata = bgmc_pkg::APB_DATA_W'(cfg_q.double_gap_ms);
      bgmc_pkg::REG_LONG_PRESS:
        prdata = bgmc_pkg::APB_DATA_W'(cfg_q.long_press_ms);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= bgmc_pkg::DEB_W'(50);
      cfg_q.double_gap_ms <= bgmc_pkg::GAP_W'(250);
      cfg_q.long_press_ms <= bgmc_pkg::LONG_W'(800);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/bgmc_debounce.sv
// Lockout debouncer of the raw button level
module bgmc_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          raw_level_i,
  input  logic [bgmc_pkg::DEB_W-1:0]    debounce_ms_i,
  output logic                          clean_level_o
);

  logic             started_q, started_d;
  logic             stable_q, stable_d;
  bgmc_pkg::timer_t since_change_q, since_change_d;

  always_comb begin
    started_d      = 1'b1;
    stable_d       = stable_q;
    since_change_d = bgmc_pkg::sat_inc(since_change_q);
    if (!started_q) begin
      stable_d       = raw_level_i;
      since_change_d = '0;
    end
    if ((bgmc_pkg::CMP_W'(since_change_d) > bgmc_pkg::CMP_W'(debounce_ms_i)) &&
        (raw_level_i != stable_d)) begin
      stable_d       = raw_level_i;
      since_change_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      stable_q       <= 1'b0;
      since_change_q <= '0;
    end else if (step_i) begin
      started_q      <= started_d;
      stable_q       <= stable_d;
      since_change_q <= since_change_d;
    end
  end

  assign clean_level_o = stable_d;

endmodule

>>> hdl/bgmc_gesture.sv
// Single, double and long press classifier
module bgmc_gesture (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          clean_level_i,
  input  logic [bgmc_pkg::GAP_W-1:0]    double_gap_ms_i,
  input  logic [bgmc_pkg::LONG_W-1:0]   long_press_ms_i,
  output bgmc_pkg::gesture_e            gesture_o
);

  logic             held_q, held_d;
  logic             await_q, await_d;
  logic             armed_q, armed_d;
  logic             done_q, done_d;
  bgmc_pkg::timer_t since_press_q, since_press_d;
  bgmc_pkg::timer_t since_release_q, since_release_d;

  always_comb begin
    held_d          = held_q;
    await_d         = await_q;
    armed_d         = armed_q;
    done_d          = done_q;
    since_press_d   = bgmc_pkg::sat_inc(since_press_q);
    since_release_d = bgmc_pkg::sat_inc(since_release_q);
    gesture_o       = bgmc_pkg::GEST_NONE;

    if (clean_level_i && !held_d) begin
      held_d        = 1'b1;
      since_press_d = '0;
      armed_d       = 1'b1;
      done_d        = 1'b0;
    end
    if (!clean_level_i && held_d) begin
      held_d          = 1'b0;
      since_release_d = '0;
      if (done_d) begin
        armed_d = 1'b0;
      end else if (await_d) begin
        await_d   = 1'b0;
        gesture_o = bgmc_pkg::GEST_DOUBLE;
      end else begin
        await_d = 1'b1;
      end
    end
    if (held_d && armed_d && !done_d &&
        (bgmc_pkg::CMP_W'(since_press_d) > bgmc_pkg::CMP_W'(long_press_ms_i))) begin
      gesture_o = bgmc_pkg::GEST_LONG;
      done_d    = 1'b1;
      armed_d   = 1'b0;
    end
    if (await_d &&
        (bgmc_pkg::CMP_W'(since_release_d) > bgmc_pkg::CMP_W'(double_gap_ms_i))) begin
      await_d   = 1'b0;
      gesture_o = bgmc_pkg::GEST_SINGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q          <= 1'b0;
      await_q         <= 1'b0;
      armed_q         <= 1'b0;
      done_q          <= 1'b0;
      since_press_q   <= '0;
      since_release_q <= '0;
    end else if (step_i) begin
      held_q          <= held_d;
      await_q         <= await_d;
      armed_q         <= armed_d;
      done_q          <= done_d;
      since_press_q   <= since_press_d;
      since_release_q <= since_release_d;
    end
  end

endmodule

>>> hdl/bgmc_mode.sv
// Three-mode controller that turns gestures into player commands
module bgmc_mode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  bgmc_pkg::gesture_e   gesture_i,
  input  logic [1:0]           play_state_i,
  output bgmc_pkg::command_e   command_o,
  output logic [1:0]           mode_o
);

  bgmc_pkg::mode_e mode_q, mode_d;

  always_comb begin
    mode_d    = mode_q;
    command_o = bgmc_pkg::CMD_NONE;
    if (gesture_i != bgmc_pkg::GEST_NONE) begin
      unique case (mode_q)
        bgmc_pkg::MODE_PLAY: begin
          unique case (gesture_i)
            bgmc_pkg::GEST_SINGLE: begin
              if (play_state_i == bgmc_pkg::PLAY_STATE_PLAYING) begin
                command_o = bgmc_pkg::CMD_PAUSE;
              end else if (play_state_i == bgmc_pkg::PLAY_STATE_WAITING) begin
                command_o = bgmc_pkg::CMD_RESUME;
              end
            end
            bgmc_pkg::GEST_DOUBLE: mode_d = bgmc_pkg::MODE_TRACK;
            default:               mode_d = bgmc_pkg::MODE_VOL;
          endcase
        end
        bgmc_pkg::MODE_TRACK: begin
          unique case (gesture_i)
            bgmc_pkg::GEST_SINGLE: command_o = bgmc_pkg::CMD_PREVIOUS;
            bgmc_pkg::GEST_DOUBLE: command_o = bgmc_pkg::CMD_NEXT;
            default:               mode_d    = bgmc_pkg::MODE_PLAY;
          endcase
        end
        bgmc_pkg::MODE_VOL: begin
          unique case (gesture_i)
            bgmc_pkg::GEST_SINGLE: command_o = bgmc_pkg::CMD_VOL_DOWN;
            bgmc_pkg::GEST_DOUBLE: command_o = bgmc_pkg::CMD_VOL_UP;
            default:               mode_d    = bgmc_pkg::MODE_PLAY;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mode_d)
      bgmc_pkg::MODE_TRACK: mode_o = bgmc_pkg::MODE_CODE_TRACK;
      bgmc_pkg::MODE_VOL:   mode_o = bgmc_pkg::MODE_CODE_VOL;
      default:              mode_o = bgmc_pkg::MODE_CODE_PLAY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bgmc_pkg::MODE_PLAY;
    end else if (step_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

>>> hdl/button_gesture_mode_controller.sv
// Top level: input register, per-tick update and result register
// An accepted word waits in the input register, and its result is registered in
// the result register unless the output stalls. Throughput: one word per cycle
// while the output is not stalled; all state updates fit between the two registers.
// Reset: asynchronous, active low; clears the input register, the result valid flag,
// all gesture state and restores the configuration registers to 50, 250 and 800.
module button_gesture_mode_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             raw_level_i,
  input  logic [1:0]                       play_state_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       gesture_o,
  output logic [2:0]                       command_o,
  output logic [1:0]                       mode_o,
  output logic                             clean_level_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bgmc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bgmc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bgmc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  bgmc_pkg::cfg_t     cfg;
  bgmc_pkg::word_t    in_q, in_d;
  bgmc_pkg::gesture_e gesture;
  bgmc_pkg::command_e command;
  logic               clean_level;
  logic [1:0]         mode;
  logic               advance;
  logic               step;
  logic               in_accept;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         gesture_q;
  logic [2:0]         command_q;
  logic [1:0]         mode_q;
  logic               clean_q;

  assign advance    = !(out_valid_q && out_stall_i);
  assign step       = in_q.valid && advance;
  assign in_stall_o = in_q.valid && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_d = in_q;
    if (in_accept) begin
      in_d.valid      = 1'b1;
      in_d.raw_level  = raw_level_i;
      in_d.play_state = play_state_i;
    end else if (advance) begin
      in_d.valid = 1'b0;
    end
  end

  assign out_valid_d = advance ? in_q.valid : out_valid_q;

  bgmc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bgmc_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .raw_level_i   (in_q.raw_level),
    .debounce_ms_i (cfg.debounce_ms),
    .clean_level_o (clean_level)
  );

  bgmc_gesture u_gesture (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .clean_level_i   (clean_level),
    .double_gap_ms_i (cfg.double_gap_ms),
    .long_press_ms_i (cfg.long_press_ms),
    .gesture_o       (gesture)
  );

  bgmc_mode u_mode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .gesture_i    (gesture),
    .play_state_i (in_q.play_state),
    .command_o    (command),
    .mode_o       (mode)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_q        <= in_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      gesture_q <= gesture;
      command_q <= command;
      mode_q    <= mode;
      clean_q   <= clean_level;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign gesture_o     = gesture_q;
  assign command_o     = command_q;
  assign mode_o        = mode_q;
  assign clean_level_o = clean_q;

endmodule

>>> hdl/bgmc_checker.sv
// Port-level checker of the button gesture mode controller, bound to the top level
`include "assert_macros.svh"

module bgmc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] gesture_o,
  input logic [2:0] command_o,
  input logic [1:0] mode_o
);

  logic       out_held;
  logic [4:0] result_word;
  logic       cmd_set;
  logic       gest_set;
  logic       is_long;
  logic       is_double;
  logic       no_cmd;
  logic       double_cmd_ok;
  logic       mode_ok;

  assign out_held      = out_valid_o && out_stall_i;
  assign result_word   = {gesture_o, command_o};
  assign cmd_set       = out_valid_o && (command_o != bgmc_pkg::CMD_NONE);
  assign gest_set      = gesture_o != bgmc_pkg::GEST_NONE;
  assign is_long       = out_valid_o && (gesture_o == bgmc_pkg::GEST_LONG);
  assign is_double     = out_valid_o && (gesture_o == bgmc_pkg::GEST_DOUBLE);
  assign no_cmd        = command_o == bgmc_pkg::CMD_NONE;
  assign double_cmd_ok = no_cmd || (command_o == bgmc_pkg::CMD_NEXT) ||
                         (command_o == bgmc_pkg::CMD_VOL_UP);
  assign mode_ok       = (mode_o == bgmc_pkg::MODE_CODE_PLAY) ||
                         (mode_o == bgmc_pkg::MODE_CODE_TRACK) ||
                         (mode_o == bgmc_pkg::MODE_CODE_VOL);

  `BGMC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(result_word))
  `BGMC_ASSERT_IMP(a_cmd_needs_gesture, clk_i, rst_ni, cmd_set, gest_set)
  `BGMC_ASSERT_IMP(a_long_no_cmd, clk_i, rst_ni, is_long, no_cmd)
  `BGMC_ASSERT_IMP(a_double_cmd, clk_i, rst_ni, is_double, double_cmd_ok)
  `BGMC_ASSERT_IMP(a_mode_legal, clk_i, rst_ni, out_valid_o, mode_ok)

endmodule

bind button_gesture_mode_controller bgmc_checker u_bgmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .gesture_o   (gesture_o),
  .command_o   (command_o),
  .mode_o      (mode_o)
);

>>> tb/bgmc_outcome_checker.sv
`timescale 1ns / 100ps
// Outcome checker: predicts every tick word's result and compares it with the block's output
module bgmc_outcome_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            raw_level_i,
  input  logic [1:0]                      play_state_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [1:0]                      gesture_i,
  input  logic [2:0]                      command_i,
  input  logic [1:0]                      mode_i,
  input  logic                            clean_level_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bgmc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bgmc_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o
);

  localparam logic [bgmc_pkg::DEB_W-1:0]  DebounceAtReset  = bgmc_pkg::DEB_W'(50);
  localparam logic [bgmc_pkg::GAP_W-1:0]  DoubleGapAtReset = bgmc_pkg::GAP_W'(250);
  localparam logic [bgmc_pkg::LONG_W-1:0] LongPressAtReset = bgmc_pkg::LONG_W'(800);
  localparam int unsigned                 ReportedMax      = 10;

  typedef struct packed {
    bgmc_pkg::gesture_e gesture;
    bgmc_pkg::command_e command;
    logic [1:0]         mode;
    logic               clean_level;
  } tick_outcome_t;

  logic [bgmc_pkg::DEB_W-1:0]  debounce_ms;
  logic [bgmc_pkg::GAP_W-1:0]  double_gap_ms;
  logic [bgmc_pkg::LONG_W-1:0] long_press_ms;

  logic             started;
  logic             stable_level;
  logic             held;
  logic             second_awaited;
  logic             long_armed;
  logic             long_done;
  bgmc_pkg::timer_t since_change;
  bgmc_pkg::timer_t since_press;
  bgmc_pkg::timer_t since_release;
  logic [1:0]       mode_now;

  tick_outcome_t awaited_outcomes[$];
  int unsigned   results_seen;

  function automatic bgmc_pkg::timer_t bump(input bgmc_pkg::timer_t v);
    bump = (&v) ? v : v + bgmc_pkg::timer_t'(1);
  endfunction

  task automatic predict_tick(input logic raw, input logic [1:0] play,
                              output tick_outcome_t res);
    bgmc_pkg::gesture_e gest;
    bgmc_pkg::command_e cmd;
    gest = bgmc_pkg::GEST_NONE;
    cmd  = bgmc_pkg::CMD_NONE;

    if (!started) begin
      stable_level = raw;
      since_change = '0;
      started      = 1'b1;
    end else begin
      since_change = bump(since_change);
    end
    if (since_change > debounce_ms && raw != stable_level) begin
      stable_level = raw;
      since_change = '0;
    end

    since_press   = bump(since_press);
    since_release = bump(since_release);

    if (stable_level && !held) begin
      held        = 1'b1;
      since_press = '0;
      long_armed  = 1'b1;
      long_done   = 1'b0;
    end
    if (!stable_level && held) begin
      held          = 1'b0;
      since_release = '0;
      if (long_done) begin
        long_armed = 1'b0;
      end else if (second_awaited) begin
        second_awaited = 1'b0;
        gest           = bgmc_pkg::GEST_DOUBLE;
      end else begin
        second_awaited = 1'b1;
      end
    end
    if (held && long_armed && !long_done && since_press > long_press_ms) begin
      gest       = bgmc_pkg::GEST_LONG;
      long_done  = 1'b1;
      long_armed = 1'b0;
    end
    if (second_awaited && since_release > double_gap_ms) begin
      second_awaited = 1'b0;
      gest           = bgmc_pkg::GEST_SINGLE;
    end

    if (gest != bgmc_pkg::GEST_NONE) begin
      case (mode_now)
        bgmc_pkg::MODE_CODE_PLAY: begin
          case (gest)
            bgmc_pkg::GEST_SINGLE: begin
              if (play == bgmc_pkg::PLAY_STATE_PLAYING) cmd = bgmc_pkg::CMD_PAUSE;
              else if (play == bgmc_pkg::PLAY_STATE_WAITING) cmd = bgmc_pkg::CMD_RESUME;
            end
            bgmc_pkg::GEST_DOUBLE: mode_now = bgmc_pkg::MODE_CODE_TRACK;
            default:               mode_now = bgmc_pkg::MODE_CODE_VOL;
          endcase
        end
        bgmc_pkg::MODE_CODE_TRACK: begin
          case (gest)
            bgmc_pkg::GEST_SINGLE: cmd = bgmc_pkg::CMD_PREVIOUS;
            bgmc_pkg::GEST_DOUBLE: cmd = bgmc_pkg::CMD_NEXT;
            default:               mode_now = bgmc_pkg::MODE_CODE_PLAY;
          endcase
        end
        bgmc_pkg::MODE_CODE_VOL: begin
          case (gest)
            bgmc_pkg::GEST_SINGLE: cmd = bgmc_pkg::CMD_VOL_DOWN;
            bgmc_pkg::GEST_DOUBLE: cmd = bgmc_pkg::CMD_VOL_UP;
            default:               mode_now = bgmc_pkg::MODE_CODE_PLAY;
          endcase
        end
        default: ;
      endcase
    end

    res = '{gesture: gest, command: cmd, mode: mode_now, clean_level: stable_level};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_outcome_t seen;
    tick_outcome_t want;
    if (!rst_ni) begin
      debounce_ms    = DebounceAtReset;
      double_gap_ms  = DoubleGapAtReset;
      long_press_ms  = LongPressAtReset;
      started        = 1'b0;
      stable_level   = 1'b0;
      held           = 1'b0;
      second_awaited = 1'b0;
      long_armed     = 1'b0;
      long_done      = 1'b0;
      since_change   = '0;
      since_press    = '0;
      since_release  = '0;
      mode_now       = bgmc_pkg::MODE_CODE_PLAY;
      awaited_outcomes.delete();
      results_seen   = 0;
      mismatches_o   = 0;
      pending_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{gesture: bgmc_pkg::gesture_e'(gesture_i),
                 command: bgmc_pkg::command_e'(command_i),
                 mode: mode_i, clean_level: clean_level_i};
        if (awaited_outcomes.size() == 0) begin
          if (mismatches_o < ReportedMax)
            $display("checker: result word %0d arrived with none awaited", results_seen);
          mismatches_o++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (seen !== want) begin
            if (mismatches_o < ReportedMax)
              $display("checker: word %0d expected g%0d c%0d m%0d l%0d got g%0d c%0d m%0d l%0d",
                       results_seen, want.gesture, want.command, want.mode,
                       want.clean_level, seen.gesture, seen.command, seen.mode,
                       seen.clean_level);
            mismatches_o++;
          end
        end
        results_seen++;
      end

      if (in_valid_i && !in_stall_i) begin
        predict_tick(raw_level_i, play_state_i, want);
        awaited_outcomes.push_back(want);
      end

      if (psel && penable && pwrite && pready) begin
        case (bgmc_pkg::reg_idx_e'(paddr[3:2]))
          bgmc_pkg::REG_DEBOUNCE:   debounce_ms   = pwdata[bgmc_pkg::DEB_W-1:0];
          bgmc_pkg::REG_DOUBLE_GAP: double_gap_ms = pwdata[bgmc_pkg::GAP_W-1:0];
          bgmc_pkg::REG_LONG_PRESS: long_press_ms = pwdata[bgmc_pkg::LONG_W-1:0];
          default: ;
        endcase
      end

      pending_o = awaited_outcomes.size();
    end
  end

endmodule

>>> tb/button_gesture_mode_controller_tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, tick stimulus, timing settings and verdict for the gesture controller
module button_gesture_mode_controller_tb;

  localparam int unsigned CycleLimit    = 800_000;
  localparam int unsigned HoldoffCycles = 80;
  localparam int unsigned PhaseTicks    = 150;
  localparam int unsigned NumPhases     = 6;
  localparam int          SpanCap       = 300;
  localparam int          ScriptLen     = 23;
  localparam logic [0:ScriptLen-1] ScriptRaw = 23'b10111101010000100001110;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mix_e;

  typedef enum int {
    SHAPE_SINGLE,
    SHAPE_DOUBLE,
    SHAPE_LONG,
    SHAPE_NOISE,
    SHAPE_EDGE
  } press_shape_e;

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic                            raw_level_i  = 1'b0;
  logic [1:0]                      play_state_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic [1:0]                      gesture_o;
  logic [2:0]                      command_o;
  logic [1:0]                      mode_o;
  logic                            clean_level_o;
  logic                            psel         = 1'b0;
  logic                            penable      = 1'b0;
  logic                            pwrite       = 1'b0;
  logic [bgmc_pkg::APB_ADDR_W-1:0] paddr        = '0;
  logic [bgmc_pkg::APB_DATA_W-1:0] pwdata       = '0;
  logic [bgmc_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  int unsigned mismatches;
  int unsigned outstanding;
  idle_mix_e   idle_mix      = IDLE_NONE;
  int unsigned holdoff_req   = 0;
  int unsigned holdoff_seen  = 0;
  int unsigned holdoff_left  = 0;
  int          cfg_deb       = 0;
  int          cfg_gap       = 0;
  int          cfg_long      = 0;
  int unsigned ticks_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned cycles        = 0;

  button_gesture_mode_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_level_i   (raw_level_i),
    .play_state_i  (play_state_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .gesture_o     (gesture_o),
    .command_o     (command_o),
    .mode_o        (mode_o),
    .clean_level_o (clean_level_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bgmc_outcome_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .raw_level_i   (raw_level_i),
    .play_state_i  (play_state_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .gesture_i     (gesture_o),
    .command_i     (command_o),
    .mode_i        (mode_o),
    .clean_level_i (clean_level_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches_o  (mismatches),
    .pending_o     (outstanding)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic idles(input bit side_active);
    idles = side_active && ($urandom_range(0, 99) < ((idle_mix == IDLE_BOTH) ? 11 : 58));
  endfunction

  always @(posedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall_i <= 1'b1;
    end else if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HoldoffCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idles(idle_mix == IDLE_RECV || idle_mix == IDLE_BOTH);
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_tick(input logic raw);
    while (idles(idle_mix == IDLE_SEND || idle_mix == IDLE_BOTH)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_level_i  <= raw;
    play_state_i <= 2'($urandom_range(0, 3));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  // bounce the pin while the lockout is still open
  task automatic drive_level(input logic level, input int ticks);
    for (int k = 0; k < ticks; k++)
      send_tick((k < cfg_deb && $urandom_range(0, 3) == 0) ? ~level : level);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  task automatic apb_write(input bgmc_pkg::reg_idx_e idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_timing(input int deb, input int gap, input int lng);
    wait_drained();
    apb_write(bgmc_pkg::REG_DEBOUNCE, deb);
    apb_write(bgmc_pkg::REG_DOUBLE_GAP, gap);
    apb_write(bgmc_pkg::REG_LONG_PRESS, lng);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_deb  = deb;
    cfg_gap  = gap;
    cfg_long = lng;
    settings_used++;
  endtask

  task automatic run_gesture();
    int           d;
    int           g;
    int           l;
    int           pick;
    press_shape_e shape;
    d    = (cfg_deb > SpanCap) ? SpanCap : cfg_deb;
    g    = (cfg_gap > SpanCap) ? SpanCap : cfg_gap;
    l    = (cfg_long > SpanCap) ? SpanCap : cfg_long;
    pick = $urandom_range(0, 9);
    if (pick < 3) shape = SHAPE_SINGLE;
    else if (pick < 6) shape = SHAPE_DOUBLE;
    else if (pick < 8) shape = SHAPE_LONG;
    else if (pick == 8) shape = SHAPE_NOISE;
    else shape = SHAPE_EDGE;

    case (shape)
      SHAPE_SINGLE: begin
        drive_level(1'b1, d + 1 + $urandom_range(0, l));
        drive_level(1'b0, d + g + 2 + $urandom_range(0, 4));
      end
      SHAPE_DOUBLE: begin
        drive_level(1'b1, d + 1 + $urandom_range(0, l / 2));
        drive_level(1'b0, d + 1 + $urandom_range(0, g));
        drive_level(1'b1, d + 1 + $urandom_range(0, l / 2));
        drive_level(1'b0, d + g + 2 + $urandom_range(0, 4));
      end
      SHAPE_LONG: begin
        drive_level(1'b1, d + l + 2 + $urandom_range(0, 6));
        drive_level(1'b0, d + 2 + $urandom_range(0, g + 4));
      end
      SHAPE_NOISE: begin
        repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
      end
      default: begin
        // straddle the long and gap thresholds, then a stray short press
        drive_level(1'b1, l + $urandom_range(0, 3));
        drive_level(1'b0, g + $urandom_range(0, 3));
        drive_level(1'b1, $urandom_range(1, d + 3));
        drive_level(1'b0, d + g + 3);
      end
    endcase
  endtask

  initial begin
    int unsigned start;
    bit          pushed;
    bit          paused;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_timing(0, 2, 1);
    for (int k = 0; k < ScriptLen; k++) send_tick(ScriptRaw[k]);

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) set_timing(0, 0, 0);
      else set_timing($urandom_range(0, 8), $urandom_range(0, 40), $urandom_range(0, 60));
      idle_mix = idle_mix_e'(p % 4);
      start    = ticks_sent;
      pushed   = 1'b0;
      paused   = 1'b0;
      while (ticks_sent - start < PhaseTicks) begin
        if (!pushed && ticks_sent - start >= PhaseTicks / 4) begin
          holdoff_req <= holdoff_req + 1;
          pushed = 1'b1;
        end
        if (!paused && ticks_sent - start >= PhaseTicks / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        run_gesture();
      end
    end

    set_timing(50, 250, 800);
    idle_mix = IDLE_BOTH;
    run_gesture();

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("run covered %0d ticks under %0d timing settings, idle mixes and stall bursts,",
             ticks_sent, settings_used);
    $display("including zero thresholds, pin bounce and a gesture at the default timings");
    if (mismatches == 0 && outstanding == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
